### hw/rtl/rpf_pkg.sv
// Shared types and sizes for the retention prune filter.
// Used by rpf_cell and retention_prune_filter_core; no dependencies.
`timescale 1ns / 1ps

package rpf_pkg;

  localparam int ENTRIES = 64;

  typedef struct packed {
    logic [31:0] index_no;
    logic [31:0] page_id;
    logic [7:0]  tree_level;
    logic [63:0] lsn_limit;
    logic [47:0] now_ms;
  } req_t;

  typedef struct packed {
    logic capture;
    logic clear;
    logic apply_hit;
  } cell_ctl_t;

  typedef struct packed {
    logic match;
    logic hit_prune;
    logic claim;
    logic pass;
  } cell_stat_t;

endpackage

### hw/rtl/retention_prune_filter_core.sv
// Top level of the retention prune filter: control sequencer, totals and
// the row of rpf_cell entries. Depends on rpf_pkg and rpf_cell.
`timescale 1ns / 1ps

// Usage. A request on the input channel (in_valid/in_ready) carries mode,
// the key (index_no, page_id, tree_level), lsn_limit and now_ms. One result
// per request leaves on the output channel (out_valid/out_ready) with prune,
// table_full and the saturating pruned_total and skipped_total.
// The user writes retention_ms over the cfg_valid/cfg_ready channel only
// while idle; the block itself does not enforce this (cfg_ready is tied high).
// Timing. A request whose key is in the table passes the capture, decide
// and done states before its result; a clear skips decide. A new key passes
// a token down the chain of entries, one entry a cycle, to find the lowest
// free slot during the scan state. One request is in work at a time; the
// next is taken once the result is loaded into the output register.
// Reset clears every entry valid bit, the totals and retention_ms at once.
// A stalled receiver holds the result in the output register; a finished
// request then waits until that register is free.
module retention_prune_filter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [31:0] index_no,
  input  logic [31:0] page_id,
  input  logic [7:0]  tree_level,
  input  logic [63:0] lsn_limit,
  input  logic [47:0] now_ms,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] retention_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        prune,
  output logic        table_full,
  output logic [31:0] pruned_total,
  output logic [31:0] skipped_total
);
  import rpf_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CAP  = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]  state, state_next;
  req_t        req;
  logic        req_clear;
  logic [31:0] retention;
  logic        res_prune, res_full;
  logic        res_prune_next, res_full_next;

  cell_ctl_t   ctl;
  cell_stat_t  stat [ENTRIES];
  logic [ENTRIES:0]   tok;
  logic        tok_start;
  logic [ENTRIES-1:0] match_vec, claim_vec;
  logic        any_match, any_hit_prune, any_claim, out_free;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    any_hit_prune = 1'b0;
    tok[0]        = tok_start;
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i]  = stat[i].match;
      claim_vec[i]  = stat[i].claim;
      tok[i+1]      = stat[i].pass;
      any_hit_prune = any_hit_prune | stat[i].hit_prune;
    end
  end
  assign any_match = |match_vec;
  assign any_claim = |claim_vec;

  always_comb begin
    state_next     = state;
    res_prune_next = res_prune;
    res_full_next  = res_full;
    ctl            = '0;
    tok_start      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CAP;
        end
      end
      S_CAP: begin
        ctl.capture = !req_clear;
        ctl.clear   = req_clear;
        if (req_clear) begin
          res_prune_next = 1'b0;
          res_full_next  = 1'b0;
          state_next     = S_DONE;
        end else begin
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (any_match) begin
          ctl.apply_hit  = 1'b1;
          res_prune_next = any_hit_prune;
          res_full_next  = 1'b0;
          state_next     = S_DONE;
        end else begin
          tok_start  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (any_claim || tok[ENTRIES]) begin
          res_prune_next = 1'b1;
          res_full_next  = !any_claim;
          state_next     = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    rpf_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .req       (req),
      .retention (retention),
      .ctl       (ctl),
      .tok_in    (tok[g]),
      .stat      (stat[g])
    );
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_clear      <= mode;
      req.index_no   <= index_no;
      req.page_id    <= page_id;
      req.tree_level <= tree_level;
      req.lsn_limit  <= lsn_limit;
      req.now_ms     <= now_ms;
    end
    res_prune <= res_prune_next;
    res_full  <= res_full_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      retention     <= 32'd0;
      out_valid     <= 1'b0;
      prune         <= 1'b0;
      table_full    <= 1'b0;
      pruned_total  <= 32'd0;
      skipped_total <= 32'd0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        retention <= retention_ms;
      end
      if (state == S_DONE && out_free) begin
        out_valid  <= 1'b1;
        prune      <= res_prune;
        table_full <= res_full;
        if (!req_clear) begin
          if (res_prune && pruned_total != 32'hFFFF_FFFF) begin
            pruned_total <= pruned_total + 32'd1;
          end
          if (!res_prune && skipped_total != 32'hFFFF_FFFF) begin
            skipped_total <= skipped_total + 32'd1;
          end
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_match_unique: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEC) |-> $onehot0(match_vec))
    else $error("more than one entry matched the key");

  a_claim_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(claim_vec))
    else $error("more than one entry claimed the free-slot token");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(pruned_total)))
    else $error("stalled result changed");

  a_total_mono: assert property (@(posedge clk) disable iff (rst)
    (state != S_DONE) |=> $stable(pruned_total) && $stable(skipped_total))
    else $error("totals moved outside result delivery");

endmodule

### hw/rtl/rpf_cell.sv
// One table entry of the retention prune filter with its match logic and
// a stage of the free-slot token chain. Depends on rpf_pkg.
`timescale 1ns / 1ps

module rpf_cell (
  input  logic               clk,
  input  logic               rst,
  input  rpf_pkg::req_t      req,
  input  logic [31:0]        retention,
  input  rpf_pkg::cell_ctl_t ctl,
  input  logic               tok_in,
  output rpf_pkg::cell_stat_t stat
);
  import rpf_pkg::*;

  logic        valid;
  logic [31:0] e_index;
  logic [31:0] e_page;
  logic [7:0]  e_level;
  logic [63:0] e_lsn;
  logic [47:0] e_seen;
  logic [47:0] e_pruned;

  logic f_match, f_live, f_lsn_lt, f_aged_pr, tok;
  logic [47:0] d_seen, d_pruned;
  logic aged_seen, aged_pr, ret_zero, claim;

  assign ret_zero  = (retention == 32'd0);
  assign d_seen    = req.now_ms - e_seen;
  assign d_pruned  = req.now_ms - e_pruned;
  assign aged_seen = !ret_zero && (d_seen >= {16'd0, retention});
  assign aged_pr   = !ret_zero && (d_pruned >= {16'd0, retention});
  assign claim     = tok && !f_live;

  assign stat.match     = f_match;
  assign stat.hit_prune = f_match && (!f_live || f_lsn_lt || ret_zero || f_aged_pr);
  assign stat.claim     = claim;
  assign stat.pass      = tok && f_live;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      tok   <= 1'b0;
    end else begin
      tok <= tok_in;
      if (ctl.clear) begin
        valid <= 1'b0;
      end else if (claim) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      f_match   <= valid && (e_index == req.index_no) && (e_page == req.page_id)
                   && (e_level == req.tree_level);
      f_live    <= valid && !aged_seen;
      f_lsn_lt  <= (e_lsn < req.lsn_limit);
      f_aged_pr <= aged_pr;
    end
    // A stale matching entry is rewritten as a new key in its own slot.
    if (claim || (ctl.apply_hit && f_match && !f_live)) begin
      e_index  <= req.index_no;
      e_page   <= req.page_id;
      e_level  <= req.tree_level;
      e_lsn    <= req.lsn_limit;
      e_seen   <= req.now_ms;
      e_pruned <= req.now_ms;
    end else if (ctl.apply_hit && f_match) begin
      e_seen <= req.now_ms;
      if (f_lsn_lt || f_aged_pr) begin
        e_lsn    <= req.lsn_limit;
        e_pruned <= req.now_ms;
      end
    end
  end

endmodule
